FILE: hw/rtl/emcd_pkg.sv
// ----------------------------------------------------------------------------
// emcd_pkg
// Constants and helpers for the millisecond-timestamp to civil date pipeline.
// ----------------------------------------------------------------------------
package emcd_pkg;

   localparam int NUM_STAGES = 17;

   localparam int DAYS_TO_MARCH    = 719468;
   localparam int DAYS_PER_ERA     = 146097;
   localparam int MS_PER_DAY       = 86400 * 1000;
   localparam int ERA_BIAS         = 8;
   localparam int YEARS_PER_ERA    = 400;
   localparam int DAYS_PER_CENTURY = 36524;
   localparam int YEARS_PER_CENT   = 100;

   // shifts every reachable instant to a non-negative count from a leap-era start
   localparam longint EPOCH_BIAS_MS =
      (longint'(DAYS_TO_MARCH) + longint'(ERA_BIAS) * longint'(DAYS_PER_ERA))
      * longint'(MS_PER_DAY);
   localparam logic [48:0] EPOCH_BIAS = 49'(EPOCH_BIAS_MS);

   localparam logic [14:0] YEAR_BIAS = 15'(ERA_BIAS * YEARS_PER_ERA);

   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [10:0] OFFSET_RECIP  = 11'd1093;

   // day length in units of 1024 ms
   localparam logic [16:0] DAY_UNITS  = 17'd84375;
   localparam logic [22:0] DAY_RECIP  = 23'd6515624;
   localparam logic [17:0] ERA_DAYS   = 18'(DAYS_PER_ERA);
   localparam logic [4:0]  ERA_RECIP  = 5'd28;
   localparam logic [6:0]  SEC_UNITS  = 7'd125;
   localparam logic [17:0] SEC_RECIP  = 18'd134217;
   localparam logic [11:0] HOUR_SECS  = 12'd3600;
   localparam logic [5:0]  HOUR_RECIP = 6'd36;
   localparam logic [5:0]  MIN_SECS   = 6'd60;
   localparam logic [6:0]  MIN_RECIP  = 7'd68;
   localparam logic [10:0] QUAD_DAYS  = 11'd1460;
   localparam logic [7:0]  QUAD_RECIP = 8'd179;
   localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
   localparam logic [8:0]  YEAR_DAYS  = 9'd365;
   localparam logic [9:0]  YEAR_RECIP = 10'd718;
   localparam logic [7:0]  MP_DAYS    = 8'd153;
   localparam logic [3:0]  MP_RECIP   = 4'd13;
   localparam logic [8:0]  ERA_YEARS  = 9'(YEARS_PER_ERA);

   // first day of each month within a march-based year
   function automatic logic [8:0] month_offset(input logic [3:0] mp);
      logic [8:0] res;
      unique case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

FILE: hw/rtl/epoch_ms_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// epoch_ms_to_civil_datetime
// Converts a signed millisecond timestamp plus a programmed UTC offset into
// proleptic Gregorian year, month, day and local hour, minute and second.
// The block is a 17-stage pipeline: one beat enters per cycle while
// req_stall is low. The rate is set by the pipeline registers alone; every
// staged division by a constant is a short reciprocal multiply with one
// correction step in a later stage, and the 39-bit day division splits its
// multiply into two partial products. A stall only holds stages that are
// full, so bubbles are filled while a result waits. The offset fields come
// from the offset register, which the user must write only while the block
// is idle; the block does not enforce this. No clearing pass after reset.
// ----------------------------------------------------------------------------
module epoch_ms_to_civil_datetime (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [10:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [47:0] req_epoch_millis,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic               rsp_offset_negative,
   output logic [3:0]         rsp_offset_hours,
   output logic [5:0]         rsp_offset_minutes_part
);

   localparam int N = emcd_pkg::NUM_STAGES;

   // offset register and derived fields
   logic [26:0] off_ms_ff, off_ms_in;
   logic        off_neg_ff, off_neg_in;
   logic [3:0]  off_hours_ff, off_hours_in;
   logic [5:0]  off_mins_ff, off_mins_in;
   logic [10:0] off_abs;
   logic [21:0] off_prod;
   logic [4:0]  off_hq;
   logic [10:0] off_diff;

   // pipeline control
   logic [N-1:0] v_ff, v_in, en;

   // stage registers
   logic [48:0] s1_x_ff, s1_x_in;
   logic [38:0] s2_y_ff, s2_y_in;
   logic [6:0]  s2_frac_ff, s2_frac_in;
   logic [41:0] s2_pp_hi_ff, s2_pp_hi_in;
   logic [42:0] s2_pp_lo_ff, s2_pp_lo_in;
   logic [21:0] s3_q_ff, s3_q_in;
   logic [38:0] s3_y_ff, s3_y_in;
   logic [6:0]  s3_frac_ff, s3_frac_in;
   logic [21:0] s4_q_ff, s4_q_in;
   logic [17:0] s4_r_ff, s4_r_in;
   logic [6:0]  s4_frac_ff, s4_frac_in;
   logic [21:0] s5_z_ff, s5_z_in;
   logic [16:0] s5_r_ff, s5_r_in;
   logic [6:0]  s5_frac_ff, s5_frac_in;
   logic [21:0] s6_z_ff, s6_z_in;
   logic [4:0]  s6_era_ff, s6_era_in;
   logic [23:0] s6_v_ff, s6_v_in;
   logic [16:0] s6_sec_ff, s6_sec_in;
   logic [4:0]  s7_era_ff, s7_era_in;
   logic [18:0] s7_doe_ff, s7_doe_in;
   logic [16:0] s7_sec_ff, s7_sec_in;
   logic [7:0]  s7_sr_ff, s7_sr_in;
   logic [4:0]  s8_era_ff, s8_era_in;
   logic [17:0] s8_doe_ff, s8_doe_in;
   logic [16:0] s8_sec_ff, s8_sec_in;
   logic [4:0]  s9_era_ff, s9_era_in;
   logic [17:0] s9_doe_ff, s9_doe_in;
   logic [6:0]  s9_quad_ff, s9_quad_in;
   logic [2:0]  s9_cent_ff, s9_cent_in;
   logic        s9_last_ff, s9_last_in;
   logic [16:0] s9_sec_ff, s9_sec_in;
   logic [4:0]  s9_hour_ff, s9_hour_in;
   logic [4:0]  s10_era_ff, s10_era_in;
   logic [17:0] s10_doe_ff, s10_doe_in;
   logic [6:0]  s10_quad_ff, s10_quad_in;
   logic [2:0]  s10_cent_ff, s10_cent_in;
   logic        s10_last_ff, s10_last_in;
   logic [4:0]  s10_hour_ff, s10_hour_in;
   logic [11:0] s10_rs_ff, s10_rs_in;
   logic [4:0]  s11_era_ff, s11_era_in;
   logic [17:0] s11_doe_ff, s11_doe_in;
   logic [17:0] s11_t_ff, s11_t_in;
   logic [4:0]  s11_hour_ff, s11_hour_in;
   logic [11:0] s11_rs_ff, s11_rs_in;
   logic [5:0]  s11_min_ff, s11_min_in;
   logic [4:0]  s12_era_ff, s12_era_in;
   logic [17:0] s12_doe_ff, s12_doe_in;
   logic [17:0] s12_t_ff, s12_t_in;
   logic [8:0]  s12_yoe_ff, s12_yoe_in;
   logic [4:0]  s12_hour_ff, s12_hour_in;
   logic [5:0]  s12_min_ff, s12_min_in;
   logic [5:0]  s12_sec_ff, s12_sec_in;
   logic [4:0]  s13_era_ff, s13_era_in;
   logic [17:0] s13_doe_ff, s13_doe_in;
   logic [8:0]  s13_yoe_ff, s13_yoe_in;
   logic [4:0]  s13_hour_ff, s13_hour_in;
   logic [5:0]  s13_min_ff, s13_min_in;
   logic [5:0]  s13_sec_ff, s13_sec_in;
   logic [4:0]  s14_era_ff, s14_era_in;
   logic [8:0]  s14_yoe_ff, s14_yoe_in;
   logic [8:0]  s14_doy_ff, s14_doy_in;
   logic [4:0]  s14_hour_ff, s14_hour_in;
   logic [5:0]  s14_min_ff, s14_min_in;
   logic [5:0]  s14_sec_ff, s14_sec_in;
   logic [4:0]  s15_era_ff, s15_era_in;
   logic [8:0]  s15_yoe_ff, s15_yoe_in;
   logic [8:0]  s15_doy_ff, s15_doy_in;
   logic [3:0]  s15_mp_ff, s15_mp_in;
   logic [4:0]  s15_hour_ff, s15_hour_in;
   logic [5:0]  s15_min_ff, s15_min_in;
   logic [5:0]  s15_sec_ff, s15_sec_in;
   logic [4:0]  s16_era_ff, s16_era_in;
   logic [8:0]  s16_yoe_ff, s16_yoe_in;
   logic [8:0]  s16_doy_ff, s16_doy_in;
   logic [3:0]  s16_mp_ff, s16_mp_in;
   logic [4:0]  s16_hour_ff, s16_hour_in;
   logic [5:0]  s16_min_ff, s16_min_in;
   logic [5:0]  s16_sec_ff, s16_sec_in;
   logic [13:0] s17_year_ff, s17_year_in;
   logic [3:0]  s17_month_ff, s17_month_in;
   logic [4:0]  s17_day_ff, s17_day_in;
   logic [4:0]  s17_hour_ff, s17_hour_in;
   logic [5:0]  s17_min_ff, s17_min_in;
   logic [5:0]  s17_sec_ff, s17_sec_in;

   // combinational temporaries
   logic [61:0] day_sum;
   logic [38:0] day_back, day_diff;
   logic [17:0] r_fix;
   logic [26:0] era_prod;
   logic [41:0] sec_prod;
   logic [21:0] era_back, doe_diff;
   logic [23:0] sec_back, sec_diff;
   logic [18:0] doe_fix;
   logic [25:0] quad_prod;
   logic [22:0] hour_prod;
   logic [17:0] quad_back, quad_diff;
   logic [16:0] hour_back, hour_diff;
   logic [12:0] hour_rem, rs_fix;
   logic [18:0] min_prod;
   logic [27:0] year_prod;
   logic [11:0] min_back, min_diff;
   logic [6:0]  min_rem, sec_fix;
   logic [17:0] yoe_back, yoe_diff;
   logic [1:0]  cent_yoe;
   logic [17:0] year_start, doy_diff;
   logic [10:0] mp_num, mp_num2, mp_back, mp_diff;
   logic [14:0] mp_prod;
   logic [8:0]  day_calc;
   logic [14:0] year_calc;

   // offset register
   always_comb begin
      off_abs  = csr_wr_data[10] ? (~csr_wr_data + 11'd1) : csr_wr_data;
      off_prod = 22'(off_abs) * 22'(emcd_pkg::OFFSET_RECIP);
      off_hq   = off_prod[20:16];
      off_diff = off_abs - 11'(off_hq) * 11'(emcd_pkg::MIN_SECS);
      off_ms_in    = 27'({{16{csr_wr_data[10]}}, csr_wr_data})
                     * 27'(emcd_pkg::MS_PER_MINUTE);
      off_neg_in   = csr_wr_data[10];
      off_hours_in = (off_hq > 5'd15) ? 4'd15 : off_hq[3:0];
      off_mins_in  = off_diff[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ms_ff    <= '0;
         off_neg_ff   <= 1'b0;
         off_hours_ff <= '0;
         off_mins_ff  <= '0;
      end else if (csr_wr_en) begin
         off_ms_ff    <= off_ms_in;
         off_neg_ff   <= off_neg_in;
         off_hours_ff <= off_hours_in;
         off_mins_ff  <= off_mins_in;
      end
   end

   // a stage moves when it or any later stage is empty, or the output drains
   always_comb begin
      v_in = {v_ff[N-2:0], req_valid};
      for (int i = 0; i < N; i++) begin
         en[i] = !rsp_stall || ((~v_ff & ({N{1'b1}} << i)) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_comb begin
      // biased local time, never negative
      s1_x_in = {req_epoch_millis[47], req_epoch_millis}
                + {{22{off_ms_ff[26]}}, off_ms_ff} + emcd_pkg::EPOCH_BIAS;

      // day quotient: partial products of the reciprocal
      s2_y_in     = s1_x_ff[48:10];
      s2_frac_in  = s1_x_ff[9:3];
      s2_pp_hi_in = 42'(s1_x_ff[48:30]) * 42'(emcd_pkg::DAY_RECIP);
      s2_pp_lo_in = 43'(s1_x_ff[29:10]) * 43'(emcd_pkg::DAY_RECIP);

      day_sum    = {s2_pp_hi_ff, 20'd0} + {19'd0, s2_pp_lo_ff};
      s3_q_in    = day_sum[60:39];
      s3_y_in    = s2_y_ff;
      s3_frac_in = s2_frac_ff;

      day_back   = 39'(s3_q_ff) * 39'(emcd_pkg::DAY_UNITS);
      day_diff   = s3_y_ff - day_back;
      s4_q_in    = s3_q_ff;
      s4_r_in    = day_diff[17:0];
      s4_frac_in = s3_frac_ff;

      if (s4_r_ff >= 18'(emcd_pkg::DAY_UNITS)) begin
         s5_z_in = s4_q_ff + 22'd1;
         r_fix   = s4_r_ff - 18'(emcd_pkg::DAY_UNITS);
      end else begin
         s5_z_in = s4_q_ff;
         r_fix   = s4_r_ff;
      end
      s5_r_in    = r_fix[16:0];
      s5_frac_in = s4_frac_ff;

      // era and second-of-day estimates
      s6_z_in   = s5_z_ff;
      s6_v_in   = {s5_r_ff, s5_frac_ff};
      era_prod  = 27'(s5_z_ff) * 27'(emcd_pkg::ERA_RECIP);
      s6_era_in = era_prod[26:22];
      sec_prod  = 42'(s6_v_in) * 42'(emcd_pkg::SEC_RECIP);
      s6_sec_in = sec_prod[40:24];

      era_back  = 22'(s6_era_ff) * 22'(emcd_pkg::ERA_DAYS);
      doe_diff  = s6_z_ff - era_back;
      s7_doe_in = doe_diff[18:0];
      s7_era_in = s6_era_ff;
      sec_back  = 24'(s6_sec_ff) * 24'(emcd_pkg::SEC_UNITS);
      sec_diff  = s6_v_ff - sec_back;
      s7_sr_in  = sec_diff[7:0];
      s7_sec_in = s6_sec_ff;

      if (s7_doe_ff >= 19'(emcd_pkg::ERA_DAYS)) begin
         s8_era_in = s7_era_ff + 5'd1;
         doe_fix   = s7_doe_ff - 19'(emcd_pkg::ERA_DAYS);
      end else begin
         s8_era_in = s7_era_ff;
         doe_fix   = s7_doe_ff;
      end
      s8_doe_in = doe_fix[17:0];
      s8_sec_in = (s7_sr_ff >= 8'(emcd_pkg::SEC_UNITS)) ? s7_sec_ff + 17'd1 : s7_sec_ff;

      // leap-cycle corrections of the day of era
      s9_era_in  = s8_era_ff;
      s9_doe_in  = s8_doe_ff;
      quad_prod  = 26'(s8_doe_ff) * 26'(emcd_pkg::QUAD_RECIP);
      s9_quad_in = quad_prod[24:18];
      s9_cent_in = 3'(s8_doe_ff >= 18'(emcd_pkg::DAYS_PER_CENTURY))
                   + 3'(s8_doe_ff >= 18'(2 * emcd_pkg::DAYS_PER_CENTURY))
                   + 3'(s8_doe_ff >= 18'(3 * emcd_pkg::DAYS_PER_CENTURY))
                   + 3'(s8_doe_ff >= 18'(4 * emcd_pkg::DAYS_PER_CENTURY));
      s9_last_in = (s8_doe_ff == emcd_pkg::ERA_LAST_DAY);
      s9_sec_in  = s8_sec_ff;
      hour_prod  = 23'(s8_sec_ff) * 23'(emcd_pkg::HOUR_RECIP);
      s9_hour_in = hour_prod[21:17];

      quad_back   = 18'(s9_quad_ff) * 18'(emcd_pkg::QUAD_DAYS);
      quad_diff   = s9_doe_ff - quad_back;
      s10_quad_in = (quad_diff[11:0] >= 12'(emcd_pkg::QUAD_DAYS)) ?
                    s9_quad_ff + 7'd1 : s9_quad_ff;
      s10_era_in  = s9_era_ff;
      s10_doe_in  = s9_doe_ff;
      s10_cent_in = s9_cent_ff;
      s10_last_in = s9_last_ff;
      hour_back   = 17'(s9_hour_ff) * 17'(emcd_pkg::HOUR_SECS);
      hour_diff   = s9_sec_ff - hour_back;
      hour_rem    = hour_diff[12:0];
      if (hour_rem >= 13'(emcd_pkg::HOUR_SECS)) begin
         s10_hour_in = s9_hour_ff + 5'd1;
         rs_fix      = hour_rem - 13'(emcd_pkg::HOUR_SECS);
      end else begin
         s10_hour_in = s9_hour_ff;
         rs_fix      = hour_rem;
      end
      s10_rs_in = rs_fix[11:0];

      s11_t_in    = s10_doe_ff - 18'(s10_quad_ff) + 18'(s10_cent_ff) - 18'(s10_last_ff);
      s11_era_in  = s10_era_ff;
      s11_doe_in  = s10_doe_ff;
      s11_hour_in = s10_hour_ff;
      s11_rs_in   = s10_rs_ff;
      min_prod    = 19'(s10_rs_ff) * 19'(emcd_pkg::MIN_RECIP);
      s11_min_in  = min_prod[17:12];

      // year of era estimate, minutes and seconds
      year_prod   = 28'(s11_t_ff) * 28'(emcd_pkg::YEAR_RECIP);
      s12_yoe_in  = year_prod[26:18];
      s12_era_in  = s11_era_ff;
      s12_doe_in  = s11_doe_ff;
      s12_t_in    = s11_t_ff;
      s12_hour_in = s11_hour_ff;
      min_back    = 12'(s11_min_ff) * 12'(emcd_pkg::MIN_SECS);
      min_diff    = s11_rs_ff - min_back;
      min_rem     = min_diff[6:0];
      if (min_rem >= 7'(emcd_pkg::MIN_SECS)) begin
         s12_min_in = s11_min_ff + 6'd1;
         sec_fix    = min_rem - 7'(emcd_pkg::MIN_SECS);
      end else begin
         s12_min_in = s11_min_ff;
         sec_fix    = min_rem;
      end
      s12_sec_in = sec_fix[5:0];

      yoe_back    = 18'(s12_yoe_ff) * 18'(emcd_pkg::YEAR_DAYS);
      yoe_diff    = s12_t_ff - yoe_back;
      s13_yoe_in  = (yoe_diff[9:0] >= 10'(emcd_pkg::YEAR_DAYS)) ?
                    s12_yoe_ff + 9'd1 : s12_yoe_ff;
      s13_era_in  = s12_era_ff;
      s13_doe_in  = s12_doe_ff;
      s13_hour_in = s12_hour_ff;
      s13_min_in  = s12_min_ff;
      s13_sec_in  = s12_sec_ff;

      // day of year
      cent_yoe    = 2'(s13_yoe_ff >= 9'(emcd_pkg::YEARS_PER_CENT))
                    + 2'(s13_yoe_ff >= 9'(2 * emcd_pkg::YEARS_PER_CENT))
                    + 2'(s13_yoe_ff >= 9'(3 * emcd_pkg::YEARS_PER_CENT));
      year_start  = 18'(s13_yoe_ff) * 18'(emcd_pkg::YEAR_DAYS)
                    + 18'(s13_yoe_ff[8:2]) - 18'(cent_yoe);
      doy_diff    = s13_doe_ff - year_start;
      s14_doy_in  = doy_diff[8:0];
      s14_era_in  = s13_era_ff;
      s14_yoe_in  = s13_yoe_ff;
      s14_hour_in = s13_hour_ff;
      s14_min_in  = s13_min_ff;
      s14_sec_in  = s13_sec_ff;

      // march-based month
      mp_num      = 11'(s14_doy_ff) * 11'd5 + 11'd2;
      mp_prod     = 15'(mp_num) * 15'(emcd_pkg::MP_RECIP);
      s15_mp_in   = mp_prod[14:11];
      s15_era_in  = s14_era_ff;
      s15_yoe_in  = s14_yoe_ff;
      s15_doy_in  = s14_doy_ff;
      s15_hour_in = s14_hour_ff;
      s15_min_in  = s14_min_ff;
      s15_sec_in  = s14_sec_ff;

      mp_num2     = 11'(s15_doy_ff) * 11'd5 + 11'd2;
      mp_back     = 11'(s15_mp_ff) * 11'(emcd_pkg::MP_DAYS);
      mp_diff     = mp_num2 - mp_back;
      s16_mp_in   = (mp_diff[8:0] >= 9'(emcd_pkg::MP_DAYS)) ? s15_mp_ff + 4'd1 : s15_mp_ff;
      s16_era_in  = s15_era_ff;
      s16_yoe_in  = s15_yoe_ff;
      s16_doy_in  = s15_doy_ff;
      s16_hour_in = s15_hour_ff;
      s16_min_in  = s15_min_ff;
      s16_sec_in  = s15_sec_ff;

      // final fields
      day_calc   = s16_doy_ff - emcd_pkg::month_offset(s16_mp_ff) + 9'd1;
      s17_day_in = day_calc[4:0];
      if (s16_mp_ff < 4'd10) begin
         s17_month_in = s16_mp_ff + 4'd3;
      end else begin
         s17_month_in = s16_mp_ff - 4'd9;
      end
      year_calc   = 15'(s16_yoe_ff) + 15'(s16_era_ff) * 15'(emcd_pkg::ERA_YEARS)
                    - emcd_pkg::YEAR_BIAS + 15'(s17_month_in <= 4'd2);
      s17_year_in = year_calc[13:0];
      s17_hour_in = s16_hour_ff;
      s17_min_in  = s16_min_ff;
      s17_sec_in  = s16_sec_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_x_ff <= s1_x_in;
      end
      if (en[1]) begin
         s2_y_ff     <= s2_y_in;
         s2_frac_ff  <= s2_frac_in;
         s2_pp_hi_ff <= s2_pp_hi_in;
         s2_pp_lo_ff <= s2_pp_lo_in;
      end
      if (en[2]) begin
         s3_q_ff    <= s3_q_in;
         s3_y_ff    <= s3_y_in;
         s3_frac_ff <= s3_frac_in;
      end
      if (en[3]) begin
         s4_q_ff    <= s4_q_in;
         s4_r_ff    <= s4_r_in;
         s4_frac_ff <= s4_frac_in;
      end
      if (en[4]) begin
         s5_z_ff    <= s5_z_in;
         s5_r_ff    <= s5_r_in;
         s5_frac_ff <= s5_frac_in;
      end
      if (en[5]) begin
         s6_z_ff   <= s6_z_in;
         s6_era_ff <= s6_era_in;
         s6_v_ff   <= s6_v_in;
         s6_sec_ff <= s6_sec_in;
      end
      if (en[6]) begin
         s7_era_ff <= s7_era_in;
         s7_doe_ff <= s7_doe_in;
         s7_sec_ff <= s7_sec_in;
         s7_sr_ff  <= s7_sr_in;
      end
      if (en[7]) begin
         s8_era_ff <= s8_era_in;
         s8_doe_ff <= s8_doe_in;
         s8_sec_ff <= s8_sec_in;
      end
      if (en[8]) begin
         s9_era_ff  <= s9_era_in;
         s9_doe_ff  <= s9_doe_in;
         s9_quad_ff <= s9_quad_in;
         s9_cent_ff <= s9_cent_in;
         s9_last_ff <= s9_last_in;
         s9_sec_ff  <= s9_sec_in;
         s9_hour_ff <= s9_hour_in;
      end
      if (en[9]) begin
         s10_era_ff  <= s10_era_in;
         s10_doe_ff  <= s10_doe_in;
         s10_quad_ff <= s10_quad_in;
         s10_cent_ff <= s10_cent_in;
         s10_last_ff <= s10_last_in;
         s10_hour_ff <= s10_hour_in;
         s10_rs_ff   <= s10_rs_in;
      end
      if (en[10]) begin
         s11_era_ff  <= s11_era_in;
         s11_doe_ff  <= s11_doe_in;
         s11_t_ff    <= s11_t_in;
         s11_hour_ff <= s11_hour_in;
         s11_rs_ff   <= s11_rs_in;
         s11_min_ff  <= s11_min_in;
      end
      if (en[11]) begin
         s12_era_ff  <= s12_era_in;
         s12_doe_ff  <= s12_doe_in;
         s12_t_ff    <= s12_t_in;
         s12_yoe_ff  <= s12_yoe_in;
         s12_hour_ff <= s12_hour_in;
         s12_min_ff  <= s12_min_in;
         s12_sec_ff  <= s12_sec_in;
      end
      if (en[12]) begin
         s13_era_ff  <= s13_era_in;
         s13_doe_ff  <= s13_doe_in;
         s13_yoe_ff  <= s13_yoe_in;
         s13_hour_ff <= s13_hour_in;
         s13_min_ff  <= s13_min_in;
         s13_sec_ff  <= s13_sec_in;
      end
      if (en[13]) begin
         s14_era_ff  <= s14_era_in;
         s14_yoe_ff  <= s14_yoe_in;
         s14_doy_ff  <= s14_doy_in;
         s14_hour_ff <= s14_hour_in;
         s14_min_ff  <= s14_min_in;
         s14_sec_ff  <= s14_sec_in;
      end
      if (en[14]) begin
         s15_era_ff  <= s15_era_in;
         s15_yoe_ff  <= s15_yoe_in;
         s15_doy_ff  <= s15_doy_in;
         s15_mp_ff   <= s15_mp_in;
         s15_hour_ff <= s15_hour_in;
         s15_min_ff  <= s15_min_in;
         s15_sec_ff  <= s15_sec_in;
      end
      if (en[15]) begin
         s16_era_ff  <= s16_era_in;
         s16_yoe_ff  <= s16_yoe_in;
         s16_doy_ff  <= s16_doy_in;
         s16_mp_ff   <= s16_mp_in;
         s16_hour_ff <= s16_hour_in;
         s16_min_ff  <= s16_min_in;
         s16_sec_ff  <= s16_sec_in;
      end
      if (en[16]) begin
         s17_year_ff  <= s17_year_in;
         s17_month_ff <= s17_month_in;
         s17_day_ff   <= s17_day_in;
         s17_hour_ff  <= s17_hour_in;
         s17_min_ff   <= s17_min_in;
         s17_sec_ff   <= s17_sec_in;
      end
   end

   assign req_stall               = !en[0];
   assign rsp_valid               = v_ff[N-1];
   assign rsp_year                = $signed(s17_year_ff);
   assign rsp_month               = s17_month_ff;
   assign rsp_day_of_month        = s17_day_ff;
   assign rsp_hour                = s17_hour_ff;
   assign rsp_minute              = s17_min_ff;
   assign rsp_second              = s17_sec_ff;
   assign rsp_offset_negative     = off_neg_ff;
   assign rsp_offset_hours        = off_hours_ff;
   assign rsp_offset_minutes_part = off_mins_ff;

   // accepted beat lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted beat missing from first stage");

   // day quotient correction leaves a proper remainder
   assert property (@(posedge clock) disable iff (reset)
      v_ff[4] |-> (s5_r_ff < emcd_pkg::DAY_UNITS))
      else $error("day remainder out of range");

   // era correction leaves a proper day of era
   assert property (@(posedge clock) disable iff (reset)
      v_ff[7] |-> (s8_doe_ff < emcd_pkg::ERA_DAYS))
      else $error("day of era out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12
                     && rsp_day_of_month >= 5'd1))
      else $error("month or day out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time of day out of range");

endmodule

FILE: dv/tb_epoch_ms_to_civil_datetime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_ms_to_civil_datetime
// Self-checking bench for the timestamp to civil date and time pipeline. A
// scoreboard predicts year, month, day, time of day and the offset fields of
// every accepted timestamp under the programmed UTC offset. It compares each
// output beat field by field, in order. The run sweeps offsets from -1024 to
// 1023 minutes, the edges of the 48-bit input, day and leap-year boundaries
// and random timestamps. Both channels idle and stall in several patterns,
// and one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic signed [13:0] year;
   logic [3:0]         month;
   logic [4:0]         day_of_month;
   logic [4:0]         hour;
   logic [5:0]         minute;
   logic [5:0]         second;
   logic               offset_negative;
   logic [3:0]         offset_hours;
   logic [5:0]         offset_minutes_part;
} civil_time_type;

class civil_scoreboard;
   civil_time_type     expected_civil_q[$];
   logic signed [10:0] utc_offset;
   int unsigned        n_errors;
   int unsigned        n_sent;
   int unsigned        n_checked;

   function new();
      utc_offset = '0;
      n_errors   = 0;
      n_sent     = 0;
      n_checked  = 0;
   endfunction

   function void set_offset(logic signed [10:0] v);
      utc_offset = v;
   endfunction

   function longint div_floor(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function civil_time_type to_civil(logic signed [47:0] ms);
      civil_time_type r;
      longint      shifted_ms, secs, days, rem, z, era, doe, yoe, doy, mp, d, m, yr;
      longint      abs_off, off_h;
      shifted_ms = longint'(ms) + longint'(utc_offset) * 60000;
      secs     = div_floor(shifted_ms, 1000);
      days     = div_floor(secs, 86400);
      rem      = secs - days * 86400;
      // march-based years inside 400-year eras
      z   = days + 719468;
      era = div_floor(z, 146097);
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      yr  = yoe + era * 400 + ((m <= 2) ? 1 : 0);
      abs_off = (utc_offset < 0) ? -longint'(utc_offset) : longint'(utc_offset);
      off_h   = abs_off / 60;
      if (off_h > 15) off_h = 15;
      r.year                = 14'(yr);
      r.month               = 4'(m);
      r.day_of_month        = 5'(d);
      r.hour                = 5'(rem / 3600);
      r.minute              = 6'((rem % 3600) / 60);
      r.second              = 6'(rem % 60);
      r.offset_negative     = (utc_offset < 0);
      r.offset_hours        = 4'(off_h);
      r.offset_minutes_part = 6'(abs_off % 60);
      return r;
   endfunction

   function void note_request(logic signed [47:0] ms);
      expected_civil_q.push_back(to_civil(ms));
      n_sent++;
   endfunction

   task report(string what, longint got, longint want);
      n_errors++;
      if (n_errors <= 100)
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   task check_response(civil_time_type got);
      civil_time_type want;
      if (expected_civil_q.size() == 0) begin
         report("beat with nothing pending", longint'(got.year), 0);
         return;
      end
      want = expected_civil_q.pop_front();
      n_checked++;
      if (got.year != want.year)
         report("year", longint'(got.year), longint'(want.year));
      if (got.month != want.month) report("month", got.month, want.month);
      if (got.day_of_month != want.day_of_month)
         report("day_of_month", got.day_of_month, want.day_of_month);
      if (got.hour != want.hour) report("hour", got.hour, want.hour);
      if (got.minute != want.minute) report("minute", got.minute, want.minute);
      if (got.second != want.second) report("second", got.second, want.second);
      if (got.offset_negative != want.offset_negative)
         report("offset_negative", got.offset_negative, want.offset_negative);
      if (got.offset_hours != want.offset_hours)
         report("offset_hours", got.offset_hours, want.offset_hours);
      if (got.offset_minutes_part != want.offset_minutes_part)
         report("offset_minutes_part", got.offset_minutes_part, want.offset_minutes_part);
   endtask
endclass

module tb_epoch_ms_to_civil_datetime;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int N_SETTINGS     = 12;
   localparam int BEATS_PER_SET  = 144;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic signed [10:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic signed [47:0] req_epoch_millis;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [13:0] rsp_year;
   logic [3:0]         rsp_month;
   logic [4:0]         rsp_day_of_month;
   logic [4:0]         rsp_hour;
   logic [5:0]         rsp_minute;
   logic [5:0]         rsp_second;
   logic               rsp_offset_negative;
   logic [3:0]         rsp_offset_hours;
   logic [5:0]         rsp_offset_minutes_part;

   civil_scoreboard sb = new();

   int send_idle_pct;
   int stall_pct;
   int hold_request;

   longint boundary_ms[$] = '{
      -64'sd140737488355328, 64'sd140737488355327, 0, -1, 1, 999, 1000, -999,
      -1000, -1001, 59999, 3599999, 86399999, 86400000, -86400000, -86400001,
      64'sd951782400000, 64'sd951868799999, 64'sd951868800000,
      64'sd4107542399999, 64'sd4107542400000, -64'sd62135596800000,
      -64'sd62167219200000, -64'sd62162035200000, -64'sd62162035200001
   };

   epoch_ms_to_civil_datetime i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_epoch_millis        (req_epoch_millis),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_year                (rsp_year),
      .rsp_month               (rsp_month),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second),
      .rsp_offset_negative     (rsp_offset_negative),
      .rsp_offset_hours        (rsp_offset_hours),
      .rsp_offset_minutes_part (rsp_offset_minutes_part)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_epoch(logic signed [47:0] ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_epoch_millis <= ms;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      sb.note_request(ms);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_civil_q.size() != 0) @(posedge clock);
      repeat (emcd_pkg::NUM_STAGES + 4) @(posedge clock);
   endtask

   task automatic write_offset(logic signed [10:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_offset(v);
   endtask

   task automatic set_idling(int phase);
      case (phase)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 88; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 88; end
         default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
   endtask

   // mix of uniform, day boundaries in local time, mid range and edge values
   function automatic logic signed [47:0] pick_epoch(logic signed [10:0] off);
      longint      d, ms;
      logic [47:0] raw;
      case ($urandom_range(3))
         0: raw = {16'($urandom), $urandom};
         1: begin
            d   = longint'($urandom_range(3256000)) - 1628000;
            ms  = d * 86400000 + (longint'($urandom_range(240000)) - 120000)
                  - longint'(off) * 60000;
            raw = 48'(ms);
         end
         2: raw = 48'(longint'({9'($urandom), $urandom}) - (longint'(1) <<< 40));
         default: begin
            ms = longint'($urandom_range(32'h7fff_ffff));
            if ($urandom_range(1) == 1) raw = 48'h8000_0000_0000 + 48'(ms);
            else raw = 48'h7fff_ffff_ffff - 48'(ms);
         end
      endcase
      return raw;
   endfunction

   // output side: checks beats and drives stall, including the long hold-off
   initial begin
      civil_time_type got;
      int          hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.year                = rsp_year;
            got.month               = rsp_month;
            got.day_of_month        = rsp_day_of_month;
            got.hour                = rsp_hour;
            got.minute              = rsp_minute;
            got.second              = rsp_second;
            got.offset_negative     = rsp_offset_negative;
            got.offset_hours        = rsp_offset_hours;
            got.offset_minutes_part = rsp_offset_minutes_part;
            sb.check_response(got);
         end
         if (hold_request > 0 && !hold_done) begin
            hold_left = hold_request;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int offset_plan[N_SETTINGS];
      int k;
      int n;
      offset_plan = '{-840, 840, 1023, -1024, 960, -959, 0, 330, -570, 0, 0, 59};
      offset_plan[9]   = $urandom_range(2047) - 1024;
      offset_plan[10]  = $urandom_range(2047) - 1024;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_valid        = 1'b0;
      req_epoch_millis = '0;
      hold_request     = 0;
      set_idling(0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset offset of zero
      foreach (boundary_ms[i]) send_epoch(48'(boundary_ms[i]));
      wait_drained();

      for (k = 0; k < N_SETTINGS; k++) begin
         set_idling(k % 4);
         write_offset(11'(offset_plan[k]));
         // 48-bit edges under every offset
         send_epoch(48'(boundary_ms[0]));
         send_epoch(48'(boundary_ms[1]));
         if (k == 4) hold_request = HOLD_CYCLES;
         for (n = 0; n < BEATS_PER_SET; n++) send_epoch(pick_epoch(sb.utc_offset));
         wait_drained();
      end

      $display("converted %0d timestamps under %0d offsets, -1024 to 1023 minutes,",
               sb.n_checked, N_SETTINGS + 1);
      $display("covering both 48-bit edges, leap and era boundaries and a full stall");
      if (sb.n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", sb.n_errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/emcd_pkg.sv
hw/rtl/epoch_ms_to_civil_datetime.sv
dv/tb_epoch_ms_to_civil_datetime.sv
